// File: rtl/open_addressing_hash_table_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the hash table modules
// ---------------------------------------------------------------------------
`ifndef OPEN_ADDRESSING_HASH_TABLE_ASSERT_SVH
`define OPEN_ADDRESSING_HASH_TABLE_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define OAHT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("hash table assertion failed");

// Next-cycle implication, checked out of reset
`define OAHT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hash table assertion failed");

`endif

// File: rtl/oaht_pkg.sv
// ---------------------------------------------------------------------------
// oaht_pkg
// Shared sizes, command codes and control/status types of the hash table.
// ---------------------------------------------------------------------------
package oaht_pkg;

  localparam int unsigned CAPACITY = 256;
  localparam int unsigned SLOT_W   = $clog2(CAPACITY);
  localparam int unsigned USED_W   = SLOT_W + 1;
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned HASH_W   = 32;
  localparam int unsigned VALUE_W  = 64;
  localparam int unsigned LIMIT_W  = 8;

  localparam logic [LIMIT_W-1:0] LOAD_LIMIT_RST = 8'd192;

  typedef logic [CMD_W-1:0] cmd_t;

  localparam cmd_t CMD_GET = 2'd0;
  localparam cmd_t CMD_SET = 2'd1;
  localparam cmd_t CMD_DEL = 2'd2;

  // Controller to datapath
  typedef struct packed {
    logic start;    // latch request, read start slot
    logic advance;  // step to next slot
    logic commit;   // apply outcome, load result word
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic stop;     // probe has reached its end
  } dp_status_t;

endpackage

// File: rtl/oaht_ctrl.sv
// ---------------------------------------------------------------------------
// oaht_ctrl
// Request sequencer: accepts a word, walks the probe and hands the result to
// the output register once it is free.
// ---------------------------------------------------------------------------
`include "open_addressing_hash_table_assert.svh"

module oaht_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  input  oaht_pkg::dp_status_t   status_i,
  output oaht_pkg::ctrl_cmd_t    cmd_o
);

  typedef enum logic {
    ST_IDLE,
    ST_PROBE
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  // Decode commands from state and status
  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_IDLE: begin
        cmd_o.start = in_valid_i;
      end
      ST_PROBE: begin
        cmd_o.commit  = status_i.stop && out_free;
        cmd_o.advance = !status_i.stop;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  // Hold state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (cmd_o.start) begin
            state_q <= ST_PROBE;
          end
        end
        ST_PROBE: begin
          if (cmd_o.commit) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  `OAHT_ASSERT_NOW(a_commit_needs_stop, cmd_o.commit, status_i.stop)
  `OAHT_ASSERT_NEXT(a_commit_shows_word, cmd_o.commit, out_valid_q)
  `OAHT_ASSERT_NOW(a_no_start_busy, cmd_o.start, !cmd_o.advance && !cmd_o.commit)

endmodule

// File: rtl/oaht_dpath.sv
// ---------------------------------------------------------------------------
// oaht_dpath
// Slot stores, probe pointer, tombstone tracking, used count, load limit
// register and result word.
// ---------------------------------------------------------------------------
`include "open_addressing_hash_table_assert.svh"

module oaht_dpath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  oaht_pkg::ctrl_cmd_t            cmd_i,
  output oaht_pkg::dp_status_t           status_o,
  input  logic                           cfg_we_i,
  input  logic [oaht_pkg::LIMIT_W-1:0]   cfg_wdata_i,
  input  logic [oaht_pkg::CMD_W-1:0]     cmd_in_i,
  input  logic [oaht_pkg::KEY_W-1:0]     key_id_i,
  input  logic [oaht_pkg::HASH_W-1:0]    key_hash_i,
  input  logic [oaht_pkg::VALUE_W-1:0]   store_value_i,
  output logic                           found_o,
  output logic                           new_key_o,
  output logic                           table_full_o,
  output logic [oaht_pkg::VALUE_W-1:0]   read_value_o
);

  localparam int unsigned SW = oaht_pkg::SLOT_W;
  localparam int unsigned UW = oaht_pkg::USED_W;

  // Request registers
  oaht_pkg::cmd_t                 cmd_q;
  logic [oaht_pkg::KEY_W-1:0]     key_q;
  logic [oaht_pkg::VALUE_W-1:0]   val_q;

  // Probe state
  logic [SW-1:0] slot_q;
  logic [SW-1:0] cnt_q;
  logic          has_tomb_q;
  logic [SW-1:0] tomb_slot_q;
  logic [UW-1:0] used_q;
  logic [oaht_pkg::LIMIT_W-1:0] load_limit_q;

  // Slot stores
  logic [oaht_pkg::KEY_W-1:0]   key_mem [oaht_pkg::CAPACITY];
  logic [oaht_pkg::VALUE_W-1:0] val_mem [oaht_pkg::CAPACITY];
  logic [oaht_pkg::CAPACITY-1:0] occ_q;
  logic [oaht_pkg::CAPACITY-1:0] tmb_q;

  // Registered read port
  logic [oaht_pkg::KEY_W-1:0]   key_rd_q;
  logic [oaht_pkg::VALUE_W-1:0] val_rd_q;
  logic                         occ_rd_q;
  logic                         tmb_rd_q;

  // Result word
  logic                         found_q;
  logic                         new_key_q;
  logic                         full_q;
  logic [oaht_pkg::VALUE_W-1:0] rd_value_q;

  logic [SW-1:0] rd_addr;
  logic          bad_cmd, hit, empty, tomb_here, last;
  logic          tomb_any;
  logic [SW-1:0] tomb_sel;
  logic          room;

  // Outcome at commit
  logic          wr_key_en, wr_val_en, set_occ, set_tmb;
  logic [SW-1:0] wr_addr;
  logic          res_found, res_new, res_full, bump_used;

  // Pick the slot to read next
  always_comb begin
    if (cmd_i.start) begin
      rd_addr = key_hash_i[SW-1:0];
    end else if (cmd_i.advance) begin
      rd_addr = slot_q + SW'(1);
    end else begin
      rd_addr = slot_q;
    end
  end

  // Classify the slot under the probe
  assign bad_cmd   = (cmd_q != oaht_pkg::CMD_GET) && (cmd_q != oaht_pkg::CMD_SET) &&
                     (cmd_q != oaht_pkg::CMD_DEL);
  assign hit       = occ_rd_q && (key_rd_q == key_q);
  assign empty     = !occ_rd_q && !tmb_rd_q;
  assign tomb_here = !occ_rd_q && tmb_rd_q;
  assign last      = (cnt_q == SW'(oaht_pkg::CAPACITY - 1));
  assign status_o.stop = bad_cmd || hit || empty || last;

  assign tomb_any = has_tomb_q || tomb_here;
  assign tomb_sel = has_tomb_q ? tomb_slot_q : slot_q;
  assign room     = (used_q < UW'(load_limit_q));

  // Decide writes and result flags
  always_comb begin
    wr_key_en = 1'b0;
    wr_val_en = 1'b0;
    set_occ   = 1'b0;
    set_tmb   = 1'b0;
    wr_addr   = slot_q;
    res_found = 1'b0;
    res_new   = 1'b0;
    res_full  = 1'b0;
    bump_used = 1'b0;
    case (cmd_q)
      oaht_pkg::CMD_GET: begin
        res_found = hit;
      end
      oaht_pkg::CMD_SET: begin
        if (hit) begin
          wr_val_en = 1'b1;
        end else if (tomb_any) begin
          wr_addr   = tomb_sel;
          wr_key_en = 1'b1;
          wr_val_en = 1'b1;
          set_occ   = 1'b1;
          res_new   = 1'b1;
        end else if (empty && room) begin
          wr_key_en = 1'b1;
          wr_val_en = 1'b1;
          set_occ   = 1'b1;
          res_new   = 1'b1;
          bump_used = 1'b1;
        end else begin
          res_full  = 1'b1;
        end
      end
      oaht_pkg::CMD_DEL: begin
        if (hit) begin
          set_tmb   = 1'b1;
          res_found = 1'b1;
        end
      end
      default: begin
        res_found = 1'b0;
      end
    endcase
  end

  // Latch the request word
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      cmd_q <= cmd_in_i;
      key_q <= key_id_i;
      val_q <= store_value_i;
    end
  end

  // Advance the probe and track the first tombstone
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q      <= '0;
      cnt_q       <= '0;
      has_tomb_q  <= 1'b0;
      tomb_slot_q <= '0;
    end else begin
      slot_q <= rd_addr;
      if (cmd_i.start) begin
        cnt_q      <= '0;
        has_tomb_q <= 1'b0;
      end else if (cmd_i.advance) begin
        cnt_q <= cnt_q + SW'(1);
        if (tomb_here && !has_tomb_q) begin
          has_tomb_q  <= 1'b1;
          tomb_slot_q <= slot_q;
        end
      end
    end
  end

  // Hold load limit and used count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_limit_q <= oaht_pkg::LOAD_LIMIT_RST;
      used_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        load_limit_q <= cfg_wdata_i;
      end
      if (cmd_i.commit && bump_used) begin
        used_q <= used_q + UW'(1);
      end
    end
  end

  // Occupied and tombstone bits, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
      tmb_q <= '0;
    end else if (cmd_i.commit) begin
      if (set_occ) begin
        occ_q[wr_addr] <= 1'b1;
        tmb_q[wr_addr] <= 1'b0;
      end else if (set_tmb) begin
        occ_q[wr_addr] <= 1'b0;
        tmb_q[wr_addr] <= 1'b1;
      end
    end
  end

  // Key and value stores: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && wr_key_en) begin
      key_mem[wr_addr] <= key_q;
    end
    if (cmd_i.commit && wr_val_en) begin
      val_mem[wr_addr] <= val_q;
    end
    key_rd_q <= key_mem[rd_addr];
    val_rd_q <= val_mem[rd_addr];
    occ_rd_q <= occ_q[rd_addr];
    tmb_rd_q <= tmb_q[rd_addr];
  end

  // Load the result word
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      found_q    <= res_found;
      new_key_q  <= res_new;
      full_q     <= res_full;
      rd_value_q <= (res_found && (cmd_q == oaht_pkg::CMD_GET)) ? val_rd_q : '0;
    end
  end

  assign found_o      = found_q;
  assign new_key_o    = new_key_q;
  assign table_full_o = full_q;
  assign read_value_o = rd_value_q;

  `OAHT_ASSERT_NEXT(a_used_monotonic, 1'b1, used_q >= $past(used_q))
  `OAHT_ASSERT_NOW(a_used_bounded, 1'b1, used_q <= UW'(oaht_pkg::CAPACITY))
  `OAHT_ASSERT_NOW(a_one_outcome, cmd_i.commit, !(res_new && res_full) && !(res_found && res_new))

endmodule

// File: rtl/open_addressing_hash_table.sv
// Probe: a request probes 1..256 slots; the probe reads one slot a cycle from the
// key/value store's single registered read port. A new request word is accepted
// only once the previous one has committed its result.
// A finished result may wait in the output register while the probe holds at its end.
// Reset: occupied and tombstone bits and the used count clear at once (no sweep);
// load_limit returns to 192. Key and value stores are not cleared.
// ---------------------------------------------------------------------------
// open_addressing_hash_table
// Linear probing hash map with tombstones: get, set and delete requests.
// ---------------------------------------------------------------------------
module open_addressing_hash_table (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [oaht_pkg::CMD_W-1:0]     cmd_i,
  input  logic [oaht_pkg::KEY_W-1:0]     key_id_i,
  input  logic [oaht_pkg::HASH_W-1:0]    key_hash_i,
  input  logic [oaht_pkg::VALUE_W-1:0]   store_value_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           found_o,
  output logic                           new_key_o,
  output logic                           table_full_o,
  output logic [oaht_pkg::VALUE_W-1:0]   read_value_o,
  input  logic                           cfg_we_i,
  input  logic [oaht_pkg::LIMIT_W-1:0]   cfg_wdata_i
);

  oaht_pkg::ctrl_cmd_t  ctrl_cmd;
  oaht_pkg::dp_status_t dp_status;

  // Sequencer
  oaht_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (dp_status),
    .cmd_o       (ctrl_cmd)
  );

  // Stores and probe logic
  oaht_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (ctrl_cmd),
    .status_o      (dp_status),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .cmd_in_i      (cmd_i),
    .key_id_i      (key_id_i),
    .key_hash_i    (key_hash_i),
    .store_value_i (store_value_i),
    .found_o       (found_o),
    .new_key_o     (new_key_o),
    .table_full_o  (table_full_o),
    .read_value_o  (read_value_o)
  );

endmodule
